[rtl/dpr_pkg.sv]
// dpr_pkg: shared types, register indexes and helper functions for dib_pixel_to_rgba.
// No dependencies.
package dpr_pkg;

  localparam int unsigned CfgW = 32;
  localparam int unsigned IdxW = 3;
  // Number of quotient bits; the scaled field never divides to more than 255.
  localparam int unsigned QBits = 8;

  typedef enum logic [IdxW-1:0] {
    REG_PIXEL_MODE  = 3'd0,
    REG_RED_MASK    = 3'd1,
    REG_GREEN_MASK  = 3'd2,
    REG_BLUE_MASK   = 3'd3,
    REG_ALPHA_MASK  = 3'd4,
    REG_PREMULTIPLY = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_BGR24    = 2'd0,
    MODE_BGRX32   = 2'd1,
    MODE_BITFIELD = 2'd2,
    MODE_RSVD     = 2'd3
  } pix_mode_t;

  // Per-channel mask, already shifted down past its trailing zeros.
  typedef struct packed {
    logic [31:0] m;
    logic [4:0]  s;
    logic        nz;
  } chan_cfg_t;

  typedef struct packed {
    pix_mode_t mode;
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
    chan_cfg_t alpha;
    logic      premul;
  } cfg_t;

  function automatic logic [4:0] ctz32(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic chan_cfg_t mask_prep(input logic [31:0] mask);
    chan_cfg_t c;
    c.s  = ctz32(mask);
    c.m  = mask >> c.s;
    c.nz = (mask != 32'd0);
    return c;
  endfunction

  // round(c*a/255) input already holds c*a+127; exact for v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1;
    t = t + (t >> 8);
    return t[15:8];
  endfunction

endpackage

[rtl/dpr_if.sv]
// dpr_pix_if / dpr_rgba_if: valid/ready channels for pixel words and RGBA results.
// No dependencies.
interface dpr_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface dpr_rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

[rtl/dpr_cfg.sv]
// dpr_cfg: configuration registers; masks are normalized when written.
// Depends on dpr_pkg.
module dpr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dpr_pkg::IdxW-1:0]     cfg_index,
  input  logic [dpr_pkg::CfgW-1:0]     cfg_data,
  output dpr_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (dpr_pkg::reg_idx_t'(cfg_index))
        dpr_pkg::REG_PIXEL_MODE:  cfg.mode   <= dpr_pkg::pix_mode_t'(cfg_data[1:0]);
        dpr_pkg::REG_RED_MASK:    cfg.red    <= dpr_pkg::mask_prep(cfg_data);
        dpr_pkg::REG_GREEN_MASK:  cfg.green  <= dpr_pkg::mask_prep(cfg_data);
        dpr_pkg::REG_BLUE_MASK:   cfg.blue   <= dpr_pkg::mask_prep(cfg_data);
        dpr_pkg::REG_ALPHA_MASK:  cfg.alpha  <= dpr_pkg::mask_prep(cfg_data);
        dpr_pkg::REG_PREMULTIPLY: cfg.premul <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/dpr_chan.sv]
// dpr_chan: one channel: field extract and scale by 255, then one quotient bit per stage.
// Depends on dpr_pkg. Every register advances only while en is high.
module dpr_chan (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                word,
  input  dpr_pkg::chan_cfg_t         cc,
  output logic [dpr_pkg::QBits-1:0]  q
);

  localparam int unsigned N = dpr_pkg::QBits;

  logic [31:0] rem  [N+1];
  logic [N-1:0] quo [N+1];
  logic [31:0] field;

  assign field = (word >> cc.s) & cc.m;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (field << 8) - field;   // x*255, wraps at 32 bits
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned B = N - 1 - k;
    logic [39:0] dsh;
    logic        ge;
    assign dsh = {8'd0, cc.m} << B;
    assign ge  = ({8'd0, rem[k]} >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? 32'(({8'd0, rem[k]} - dsh)) : rem[k];
        quo[k+1] <= quo[k] | (ge ? (N'(1) << B) : N'(0));
      end
    end
  end

  assign q = cc.nz ? quo[N] : '0;

endmodule

[rtl/dib_pixel_to_rgba.sv]
// dib_pixel_to_rgba: bitmap pixel word to 8-bit RGBA, top level.
// Depends on dpr_pkg, dpr_if, dpr_cfg, dpr_chan.
//
// Usage:
//   pix  : sink of 32-bit pixel words (byte 0 lowest), valid/ready.
//   rgba : source of red/green/blue/alpha bytes, one word per pixel word.
//   cfg_we/cfg_index/cfg_data: register writes, taken at any edge with cfg_we;
//   write only while no pixel is in flight.
// Throughput: one pixel per clock. Every stage advances together while the
// output register is empty or being taken.
// From acceptance to rgba.valid a pixel passes one extract/scale stage,
// eight restoring-divide stages (one quotient bit each), one alpha multiply
// stage and the output register.
// Reset clears the config registers to zero (mode 0, all masks zero) and empties
// the pipeline. When rgba.ready is low with a word pending, the whole pipe
// holds and pix.ready drops; nothing is lost or repeated.
module dib_pixel_to_rgba (
  input  logic                     clk,
  input  logic                     rst,
  dpr_pix_if.sink                  pix,
  dpr_rgba_if.source               rgba,
  input  logic                     cfg_we,
  input  logic [dpr_pkg::IdxW-1:0] cfg_index,
  input  logic [dpr_pkg::CfgW-1:0] cfg_data
);

  localparam int unsigned D = dpr_pkg::QBits + 1;

  dpr_pkg::cfg_t cfg;
  logic          en;
  logic [D-1:0]  vld;
  logic [23:0]   wd [D];
  logic [7:0]    qr, qg, qb, qa;

  assign en        = !rgba.valid || rgba.ready;
  assign pix.ready = en;

  dpr_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  dpr_chan u_r (.clk, .en, .word(pix.pixel_word), .cc(cfg.red),   .q(qr));
  dpr_chan u_g (.clk, .en, .word(pix.pixel_word), .cc(cfg.green), .q(qg));
  dpr_chan u_b (.clk, .en, .word(pix.pixel_word), .cc(cfg.blue),  .q(qb));
  dpr_chan u_a (.clk, .en, .word(pix.pixel_word), .cc(cfg.alpha), .q(qa));

  // plain-mode word and valid travel beside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], pix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wd[0] <= pix.pixel_word[23:0];
      for (int i = 1; i < D; i++) wd[i] <= wd[i-1];
    end
  end

  // alpha multiply stage
  logic        bf, pm;
  logic        m_vld, m_bf, m_pm;
  logic [7:0]  a_sel;
  logic [7:0]  m_r, m_g, m_b, m_a;
  logic [15:0] p_r, p_g, p_b;
  logic [23:0] m_plain;

  assign bf    = (cfg.mode == dpr_pkg::MODE_BITFIELD) &&
                 (cfg.red.nz || cfg.green.nz || cfg.blue.nz);
  assign pm    = cfg.alpha.nz && cfg.premul;
  assign a_sel = cfg.alpha.nz ? qa : 8'hFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= vld[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_bf    <= bf;
      m_pm    <= pm;
      m_r     <= qr;
      m_g     <= qg;
      m_b     <= qb;
      m_a     <= a_sel;
      p_r     <= ({8'd0, qr} * {8'd0, a_sel}) + 16'd127;
      p_g     <= ({8'd0, qg} * {8'd0, a_sel}) + 16'd127;
      p_b     <= ({8'd0, qb} * {8'd0, a_sel}) + 16'd127;
      m_plain <= wd[D-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rgba.valid <= 1'b0;
    end else if (en) begin
      rgba.valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_bf) begin
        rgba.red   <= m_plain[23:16];
        rgba.green <= m_plain[15:8];
        rgba.blue  <= m_plain[7:0];
        rgba.alpha <= 8'hFF;
      end else begin
        rgba.red   <= m_pm ? dpr_pkg::div255(p_r) : m_r;
        rgba.green <= m_pm ? dpr_pkg::div255(p_g) : m_g;
        rgba.blue  <= m_pm ? dpr_pkg::div255(p_b) : m_b;
        rgba.alpha <= m_a;
      end
    end
  end

endmodule

[test/dib_pixel_to_rgba_tb.sv]
// dib_pixel_to_rgba_tb: self-checking bench for the pixel unpacker.
// Depends on dpr_pkg, dpr_if and the dib_pixel_to_rgba RTL.
module dib_pixel_to_rgba_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dpr_pkg::IdxW-1:0] cfg_index = '0;
  logic [dpr_pkg::CfgW-1:0] cfg_data = '0;

  dpr_pix_if  pix ();
  dpr_rgba_if rgba ();

  dib_pixel_to_rgba dut (
    .clk(clk), .rst(rst), .pix(pix), .rgba(rgba),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // shadow copy of the register file
  logic [1:0]  sh_mode;
  logic [31:0] sh_rmask, sh_gmask, sh_bmask, sh_amask;
  logic        sh_premul;

  rgba_t pending_rgba[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  initial begin
    pix.valid = 1'b0;
    pix.pixel_word = '0;
    rgba.ready = 1'b0;
  end

  function automatic logic [7:0] field_scale(logic [31:0] w, logic [31:0] mask);
    logic [31:0] m, x, p;
    int sh;
    if (mask == 32'd0) return 8'd0;
    m = mask;
    sh = 0;
    while (m[0] == 1'b0 && sh < 31) begin
      m = m >> 1;
      sh++;
    end
    x = (w >> sh) & m;
    p = x * 32'd255;
    return 8'(p / m);
  endfunction

  function automatic logic [7:0] alpha_scale(logic [7:0] c, logic [7:0] a);
    logic [31:0] v;
    v = 32'(c) * 32'(a) + 32'd127;
    return 8'(v / 32'd255);
  endfunction

  function automatic rgba_t decode_pixel(logic [31:0] w);
    rgba_t o;
    if (sh_mode == dpr_pkg::MODE_BITFIELD && (sh_rmask | sh_gmask | sh_bmask) != 32'd0) begin
      o.red   = field_scale(w, sh_rmask);
      o.green = field_scale(w, sh_gmask);
      o.blue  = field_scale(w, sh_bmask);
      if (sh_amask != 32'd0) begin
        o.alpha = field_scale(w, sh_amask);
        if (sh_premul) begin
          o.red   = alpha_scale(o.red, o.alpha);
          o.green = alpha_scale(o.green, o.alpha);
          o.blue  = alpha_scale(o.blue, o.alpha);
        end
      end else o.alpha = 8'd255;
    end else begin
      o.blue = w[7:0];
      o.green = w[15:8];
      o.red = w[23:16];
      o.alpha = 8'd255;
    end
    return o;
  endfunction

  // cycle limit and receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) rgba.ready <= 1'b0;
    else if (!idle_on) rgba.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rgba.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      rgba.ready <= 1'b0;
    end else rgba.ready <= 1'b1;
  end

  always @(posedge clk) begin
    rgba_t got, want;
    if (!rst && rgba.valid && rgba.ready) begin
      got = '{rgba.red, rgba.green, rgba.blue, rgba.alpha};
      if (pending_rgba.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = pending_rgba.pop_front();
        if (got.red !== want.red)
          $display("%0t: red exp %h got %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green exp %h got %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue exp %h got %h", $time, want.blue, got.blue);
        if (got.alpha !== want.alpha)
          $display("%0t: alpha exp %h got %h", $time, want.alpha, got.alpha);
        if (got !== want) errors++;
      end
    end
  end

  // valid stays up between back-to-back words; idle gaps and drain drop it
  task automatic send_pixel(logic [31:0] w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_word <= w;
    do @(posedge clk); while (!pix.ready);
    pending_rgba.insert(pending_rgba.size(), decode_pixel(w));
  endtask

  task automatic drain;
    pix.valid <= 1'b0;
    while (pending_rgba.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(dpr_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      dpr_pkg::REG_PIXEL_MODE:  sh_mode = v[1:0];
      dpr_pkg::REG_RED_MASK:    sh_rmask = v;
      dpr_pkg::REG_GREEN_MASK:  sh_gmask = v;
      dpr_pkg::REG_BLUE_MASK:   sh_bmask = v;
      dpr_pkg::REG_ALPHA_MASK:  sh_amask = v;
      dpr_pkg::REG_PREMULTIPLY: sh_premul = v[0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [1:0] md, logic [31:0] r, logic [31:0] g,
                         logic [31:0] b, logic [31:0] a, logic p);
    drain();
    write_reg(dpr_pkg::REG_PIXEL_MODE, 32'(md));
    write_reg(dpr_pkg::REG_RED_MASK, r);
    write_reg(dpr_pkg::REG_GREEN_MASK, g);
    write_reg(dpr_pkg::REG_BLUE_MASK, b);
    write_reg(dpr_pkg::REG_ALPHA_MASK, a);
    write_reg(dpr_pkg::REG_PREMULTIPLY, 32'(p));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_mask();
    int lo, wd;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: begin
        lo = $urandom_range(0, 31);
        wd = $urandom_range(1, 32 - lo);
        return ((wd == 32) ? 32'hFFFF_FFFF : ((32'd1 << wd) - 1)) << lo;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_plain_modes;
    set_cfg(dpr_pkg::MODE_BGR24, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    set_cfg(dpr_pkg::MODE_BGRX32, 32'hFF, 32'd0, 32'd0, 32'hFF00_0000, 1'b1);
    send_pixel(32'hAA55_CC33);
    send_pixel(32'hFFFF_FFFF);
    set_cfg(dpr_pkg::MODE_RSVD, 32'hFF0000, 32'hFF00, 32'hFF, 32'd0, 1'b0);
    send_pixel(32'h8001_7F80);
  endtask

  task automatic test_bitfields;
    // no colour mask: falls back to plain decode even with alpha
    set_cfg(dpr_pkg::MODE_BITFIELD, 32'd0, 32'd0, 32'd0, 32'hFF00_0000, 1'b1);
    send_pixel(32'h80C0_FFEE);
    set_cfg(dpr_pkg::MODE_BITFIELD, 32'hF800, 32'h07E0, 32'h001F, 32'd0, 1'b1);
    send_pixel(32'h0000_FFFF);
    send_pixel(32'h0000_8410);
    set_cfg(dpr_pkg::MODE_BITFIELD, 32'hFF0000, 32'hFF00, 32'hFF, 32'hFF00_0000, 1'b1);
    send_pixel(32'h80FF_8000);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    // wide masks overflow the 32-bit product
    set_cfg(dpr_pkg::MODE_BITFIELD, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            32'h7FFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8123_4567);
    send_pixel(32'h0000_0000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        if ($urandom_range(0, 3) != 0)
          set_cfg(dpr_pkg::MODE_BITFIELD, rand_mask(), rand_mask(), rand_mask(),
                  rand_mask(), 1'($urandom_range(0, 1)));
        else
          set_cfg(2'($urandom_range(0, 3)), rand_mask(), rand_mask(), rand_mask(),
                  rand_mask(), 1'($urandom_range(0, 1)));
      end
      send_pixel(rand_word());
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    set_cfg(dpr_pkg::MODE_BITFIELD, 32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF,
            32'hC000_0000, 1'b1);
    for (int i = 0; i < n; i++) send_pixel($urandom());
  endtask

  initial begin
    sh_mode = dpr_pkg::MODE_BGR24;
    sh_rmask = 0; sh_gmask = 0; sh_bmask = 0; sh_amask = 0; sh_premul = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values: mode 0
    send_pixel(32'hDEAD_BEEF);
    test_plain_modes();
    test_bitfields();
    test_random(1300);
    test_back_to_back(120);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
